// ----- hdl/llft_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llft_pkg
// Shared widths, byte codes and register indexes of the line length filter.
// ---------------------------------------------------------------------------
package llft_pkg;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int KEEP_CHARS_DEF = 60;
  localparam int DOT_COUNT      = 3;
  localparam int DOT_CNT_W      = 2;

  localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] DOT      = 8'd46;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEN = 2'd0,
    REG_MAX_LEN = 2'd1,
    REG_MAX_EN  = 2'd2
  } cfg_reg_t;

endpackage

// ----- hdl/llft_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llft_if
// Valid/ready channels of the line length filter: input bytes, output bytes
// and the configuration write port.
// ---------------------------------------------------------------------------
interface llft_in_if;
  logic                          valid;
  logic                          ready;
  logic [llft_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface llft_out_if;
  logic                          valid;
  logic                          ready;
  logic [llft_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface llft_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [llft_pkg::CFG_IDX_W-1:0] index;
  logic [llft_pkg::LEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/llft_line_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llft_line_ram
// Line store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module llft_line_ram #(
  parameter int DEPTH = llft_pkg::KEEP_CHARS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [llft_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [llft_pkg::BYTE_W-1:0] rd_data
);

  logic [llft_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/line_length_filter_truncate_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_length_filter_truncate_unit
// Keeps the head of each line in a line store, counts its length and on a
// newline replays a passing line (truncated, with "..." when long).
// ---------------------------------------------------------------------------
// Order: after a passing line's newline beat, S_DATA reads the line store into
//   its registered read data; the output register then takes the first beat.
// Throughput: one input byte per cycle while collecting a line; a passing line
//   blocks input until its newline beat is loaded; its head bytes leave at one
//   beat per cycle unless the output stalls, set by the single store read port.
// Reset: synchronous, clears length count, registers and handshake state; the
//   line store is not cleared, only entries of the current line are read.
module line_length_filter_truncate_unit #(
  parameter int KEEP_CHARS = llft_pkg::KEEP_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  llft_in_if.sink           in_ch,
  llft_out_if.source        out_ch,
  llft_cfg_if.sink          cfg
);

  localparam int AW = (KEEP_CHARS > 1) ? $clog2(KEEP_CHARS) : 1;
  localparam int KW = $clog2(KEEP_CHARS + 1);
  localparam logic [llft_pkg::LEN_W-1:0] KEEP_LEN = llft_pkg::LEN_W'(KEEP_CHARS);
  localparam logic [KW-1:0] KEEP_K = KW'(KEEP_CHARS);

  typedef enum logic [1:0] {
    S_COLLECT,
    S_DATA,
    S_TAIL
  } state_t;

  state_t                              state;
  logic [llft_pkg::LEN_W-1:0]          line_length;
  logic [llft_pkg::LEN_W-1:0]          min_len;
  logic [llft_pkg::LEN_W-1:0]          max_len;
  logic                                max_enabled;
  logic [KW-1:0]                       kept;
  logic [KW-1:0]                       idx;
  logic                                long_line;
  logic                                rd_pending;
  logic [llft_pkg::DOT_CNT_W-1:0]      dots;
  logic                                out_valid;
  logic [llft_pkg::BYTE_W-1:0]         out_byte;
  logic                                out_last;

  logic                                in_acc;
  logic                                is_nl;
  logic                                out_free;
  logic                                out_load;
  logic                                pass;
  logic                                wr_en;
  logic                                rd_en;
  logic [llft_pkg::BYTE_W-1:0]         rd_data;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_nl    = (in_ch.in_byte == llft_pkg::NEWLINE);
  assign out_free = !out_valid || out_ch.ready;
  assign out_load = ((state == S_DATA) && rd_pending && out_free) ||
                    ((state == S_TAIL) && out_free);
  assign pass     = (line_length >= min_len) && !(max_enabled && (line_length > max_len));
  assign wr_en    = in_acc && !is_nl && (line_length < KEEP_LEN);
  assign rd_en    = (state == S_DATA) && (idx != kept) && (!rd_pending || out_free);

  assign in_ch.ready  = (state == S_COLLECT);
  assign cfg.ready    = 1'b1;
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  llft_line_ram #(
    .DEPTH (KEEP_CHARS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (line_length[AW-1:0]),
    .wr_data (in_ch.in_byte),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_COLLECT;
      line_length <= '0;
      min_len     <= '0;
      max_len     <= llft_pkg::LEN_MAX;
      max_enabled <= 1'b0;
      out_valid   <= 1'b0;
      rd_pending  <= 1'b0;
      idx         <= '0;
      kept        <= '0;
      long_line   <= 1'b0;
      dots        <= '0;
      out_last    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          llft_pkg::REG_MIN_LEN: min_len     <= cfg.data;
          llft_pkg::REG_MAX_LEN: max_len     <= cfg.data;
          llft_pkg::REG_MAX_EN:  max_enabled <= cfg.data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_COLLECT: begin
          if (in_acc) begin
            if (!is_nl) begin
              if (line_length != llft_pkg::LEN_MAX) begin
                line_length <= line_length + 1'b1;
              end
            end else begin
              line_length <= '0;
              if (pass) begin
                long_line  <= (line_length > KEEP_LEN);
                kept       <= (line_length > KEEP_LEN) ? KEEP_K : line_length[KW-1:0];
                idx        <= '0;
                rd_pending <= 1'b0;
                state      <= S_DATA;
              end
            end
          end
        end
        S_DATA: begin
          if (rd_pending && out_free) begin
            out_byte  <= rd_data;
            out_last  <= 1'b0;
          end
          rd_pending <= rd_en || (rd_pending && !out_free);
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          if ((idx == kept) && !rd_pending) begin
            dots  <= long_line ? llft_pkg::DOT_CNT_W'(llft_pkg::DOT_COUNT) : '0;
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            if (dots != '0) begin
              out_byte <= llft_pkg::DOT;
              out_last <= 1'b0;
              dots     <= dots - 1'b1;
            end else begin
              out_byte <= llft_pkg::NEWLINE;
              out_last <= 1'b1;
              state    <= S_COLLECT;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

// ----- hdl/llft_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// llft_checker
// Port-level checks of the line length filter, bound to the top level.
// ---------------------------------------------------------------------------
module llft_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [llft_pkg::BYTE_W-1:0] in_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [llft_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

  // input is blocked while a line is being replayed
  a_no_in_mid_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of an emitted line");

  // an ordinary byte never stops collection
  a_collect_on: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_byte != llft_pkg::NEWLINE) |=> in_ready)
    else $error("input stalled after an ordinary byte");

endmodule

bind line_length_filter_truncate_unit llft_checker u_llft_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_byte   (in_ch.in_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

// ----- sim/line_length_filter_truncate_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_length_filter_truncate_unit_test
// Self-checking bench for the line length filter. Byte lines are streamed in
// under several length limits. A line model predicts the emitted beats (kept
// head, dots, closing newline) and a monitor checks every output beat in order.
// ---------------------------------------------------------------------------
module line_length_filter_truncate_unit_test;

  localparam int KEEP        = llft_pkg::KEEP_CHARS_DEF;
  localparam int LONG_HOLD   = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 20;
  localparam logic [llft_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [llft_pkg::BYTE_W-1:0] data;
    logic                        last;
  } line_beat_t;

  logic clk;
  logic rst;
  logic hold_req;
  int   hold_left;
  int   quiet_cycles;
  int   in_wait;
  int   out_wait;
  int   in_gap_hi;
  int   out_gap_hi;
  int   mismatch_count;

  // line model state and its copy of the registers
  logic [llft_pkg::BYTE_W-1:0] line_head [KEEP];
  logic [llft_pkg::LEN_W-1:0]  line_len;
  logic [llft_pkg::LEN_W-1:0]  lim_min_len;
  logic [llft_pkg::LEN_W-1:0]  lim_max_len;
  logic                        lim_max_en;

  logic [llft_pkg::BYTE_W-1:0] pending_bytes [$];
  line_beat_t                  line_beats_due [$];

  llft_in_if  in_ch ();
  llft_out_if out_ch ();
  llft_cfg_if cfg ();

  line_length_filter_truncate_unit #(.KEEP_CHARS(KEEP)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // advance the line model by one byte and queue the beats it releases
  task automatic filter_line_byte(input logic [llft_pkg::BYTE_W-1:0] b);
    logic        passes;
    int unsigned kept;
    if (b != llft_pkg::NEWLINE) begin
      if (line_len < KEEP) line_head[line_len] = b;
      if (line_len != llft_pkg::LEN_MAX) line_len = line_len + 1'b1;
    end else begin
      passes = (line_len >= lim_min_len);
      if (lim_max_en && line_len > lim_max_len) passes = 1'b0;
      if (passes) begin
        kept = (line_len > KEEP) ? KEEP : line_len;
        for (int i = 0; i < kept; i++) line_beats_due.push_back('{data: line_head[i], last: 1'b0});
        if (line_len > KEEP) begin
          repeat (llft_pkg::DOT_COUNT)
            line_beats_due.push_back('{data: llft_pkg::DOT, last: 1'b0});
        end
        line_beats_due.push_back('{data: llft_pkg::NEWLINE, last: 1'b1});
      end
      line_len = '0;
    end
  endtask

  // driver: one byte beat per pending item, with a drawn wait after each
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_wait     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) filter_line_byte(in_ch.in_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_wait > 0) begin
          in_ch.valid <= 1'b0;
          in_wait     <= in_wait - 1;
        end else if (pending_bytes.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= pending_bytes.pop_front();
          in_wait       <= $urandom_range(0, in_gap_hi);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each output beat against the oldest expected one
  always @(posedge clk) begin
    line_beat_t due;
    int         next_wait;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%0h last=%0b",
                                    out_ch.out_byte, out_ch.last));
        end else begin
          due = line_beats_due.pop_front();
          if (out_ch.out_byte !== due.data)
            report_mismatch($sformatf("out_byte %0h, expected %0h", out_ch.out_byte, due.data));
          if (out_ch.last !== due.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, due.last));
        end
        next_wait = $urandom_range(0, out_gap_hi);
      end else begin
        next_wait = (out_wait > 0) ? out_wait - 1 : 0;
      end
      out_wait     <= next_wait;
      out_ch.ready <= (next_wait == 0) && (hold_left == 0);
    end
  end

  // watchdog on stretches with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_length_filter_truncate_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [llft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [llft_pkg::LEN_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      llft_pkg::REG_MIN_LEN: lim_min_len = value;
      llft_pkg::REG_MAX_LEN: lim_max_len = value;
      llft_pkg::REG_MAX_EN:  lim_max_en  = value[0];
      default: ;
    endcase
  endtask

  // hold until every byte is in and every expected beat is out, then settle
  task automatic wait_line_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || line_beats_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic start_phase(input int in_hi, input int out_hi);
    @(negedge clk);
    in_gap_hi  = in_hi;
    out_gap_hi = out_hi;
  endtask

  function automatic logic [llft_pkg::BYTE_W-1:0] text_byte();
    logic [llft_pkg::BYTE_W-1:0] b;
    b = llft_pkg::BYTE_W'($urandom_range(0, 254));
    if (b >= llft_pkg::NEWLINE) b = b + 1'b1;
    return b;
  endfunction

  task automatic queue_line(input int len, input bit terminate);
    for (int i = 0; i < len; i++) pending_bytes.push_back(text_byte());
    if (terminate) pending_bytes.push_back(llft_pkg::NEWLINE);
  endtask

  // mostly short lines, now and then one around the keep boundary
  task automatic queue_random_lines(input int min_items);
    int queued;
    int len;
    queued = 0;
    while (queued < min_items) begin
      if ($urandom_range(0, 11) == 0) len = $urandom_range(KEEP - 4, KEEP + 6);
      else len = $urandom_range(0, 8);
      queue_line(len, 1'b1);
      queued += len + 1;
    end
  endtask

  initial begin
    logic [llft_pkg::LEN_W-1:0] en_word;
    clk            = 1'b0;
    rst            = 1'b1;
    hold_req       = 1'b0;
    in_gap_hi      = 0;
    out_gap_hi     = 0;
    mismatch_count = 0;
    line_len       = '0;
    lim_min_len    = '0;
    lim_max_len    = llft_pkg::LEN_MAX;
    lim_max_en     = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = '0;
    cfg.data       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset limits: empty line, then NUL and all-ones bytes
    start_phase(14, 14);
    pending_bytes.push_back(llft_pkg::NEWLINE);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h0B);
    pending_bytes.push_back(llft_pkg::NEWLINE);
    wait_line_idle();

    // window 3..5: lengths just outside and on both edges
    write_reg(llft_pkg::REG_MIN_LEN, 24'd3);
    write_reg(llft_pkg::REG_MAX_LEN, 24'd5);
    write_reg(llft_pkg::REG_MAX_EN, 24'd1);
    start_phase(0, 0);
    queue_line(2, 1'b1);
    queue_line(3, 1'b1);
    queue_line(5, 1'b1);
    queue_line(6, 1'b1);
    wait_line_idle();

    // widest window; long receiver hold-off while lines keep coming
    write_reg(llft_pkg::REG_MIN_LEN, 24'd0);
    write_reg(llft_pkg::REG_MAX_LEN, llft_pkg::LEN_MAX);
    write_reg(REG_SPARE, llft_pkg::LEN_MAX);
    start_phase(0, 0);
    queue_line(KEEP + 1, 1'b1);
    queue_random_lines(6);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_line_idle();

    // max check off through a word whose low bit is clear
    write_reg(llft_pkg::REG_MAX_LEN, 24'd0);
    write_reg(llft_pkg::REG_MAX_EN, 24'hFFFFFE);
    start_phase(14, 14);
    queue_random_lines(10);
    wait_line_idle();

    // max check on with max 0: only empty lines pass
    en_word    = llft_pkg::LEN_W'($urandom);
    en_word[0] = 1'b1;
    write_reg(llft_pkg::REG_MAX_EN, en_word);
    start_phase(3, 3);
    queue_random_lines(8);
    wait_line_idle();

    // top minimum, no max: every line dropped
    write_reg(llft_pkg::REG_MIN_LEN, llft_pkg::LEN_MAX);
    write_reg(llft_pkg::REG_MAX_EN, 24'd0);
    start_phase(0, 14);
    queue_random_lines(6);
    wait_line_idle();

    // minimum above maximum with the check on
    write_reg(llft_pkg::REG_MIN_LEN, 24'd7);
    write_reg(llft_pkg::REG_MAX_LEN, 24'd4);
    write_reg(llft_pkg::REG_MAX_EN, 24'd1);
    start_phase(14, 0);
    queue_random_lines(6);
    wait_line_idle();

    write_reg(llft_pkg::REG_MIN_LEN, llft_pkg::LEN_W'($urandom_range(0, 4)));
    write_reg(llft_pkg::REG_MAX_LEN, llft_pkg::LEN_W'($urandom_range(4, KEEP + 4)));
    start_phase(2, 6);
    queue_random_lines(12);
    wait_line_idle();

    // back to reset limits; stream ends inside a line
    write_reg(llft_pkg::REG_MIN_LEN, 24'd0);
    write_reg(llft_pkg::REG_MAX_LEN, llft_pkg::LEN_MAX);
    write_reg(llft_pkg::REG_MAX_EN, 24'd0);
    start_phase(0, 0);
    queue_random_lines(8);
    queue_line(5, 1'b0);
    wait_line_idle();
    repeat (TAIL) @(posedge clk);

    if (line_beats_due.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", line_beats_due.size()));
    if (mismatch_count == 0) begin
      $display("line_length_filter_truncate_unit verification clean");
    end else begin
      $display("line_length_filter_truncate_unit verification failed");
    end
    $finish;
  end

endmodule
